@@ rtl/core/assert_macros.svh @@
// assertion shorthands used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/gss_pkg.sv @@
package gss_pkg;

	localparam int NUM_STAGES = 15;

	typedef logic [255:0] u256_t;
	typedef logic [127:0] u128_t;

	localparam u256_t ORDER_N = {64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFE,
		64'hBAAEDCE6AF48A03B, 64'hBFD25E8CD0364141};
	localparam u256_t HALF_N = {64'h7FFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
		64'h5D576E7357A4501D, 64'hDFE92F46681B20A0};

	// rounding multipliers g1 and g2
	localparam u256_t G_MULT [2] = '{
		{64'h3086D221A7D46BCD, 64'hE86C90E49284EB15,
			64'h3DAA8A1471E8CA7F, 64'hE893209A45DBB031},
		{64'hE4437ED6010E8828, 64'h6F547FA90ABFE4C4,
			64'h221208AC9DF506C6, 64'h1571B4AE8AC47F71}};

	localparam u128_t NEG_B1 = {64'hE4437ED6010E8828, 64'h6F547FA90ABFE4C3};
	localparam u128_t LAT_B2 = {64'h3086D221A7D46BCD, 64'hE86C90E49284EB15};
	localparam u128_t LAT_A2LO = {64'h14CA50F7A8E2F3F6, 64'h57C1108D9D44CFD8};

	// lattice products: c1*(-b1), c2*b2, c1*b2, c2*a2lo
	localparam u128_t L_MULT [4] = '{NEG_B1, LAT_B2, LAT_B2, LAT_A2LO};
	localparam logic C_SEL [4] = '{1'b0, 1'b1, 1'b0, 1'b1};

	function automatic u256_t sub_mod_n(input u256_t a, input u256_t b);
		u256_t d;
		d = a - b;
		return (a < b) ? d + ORDER_N : d;
	endfunction

endpackage

@@ rtl/core/gss_in_if.sv @@
interface gss_in_if;
	logic valid;
	logic ready;
	logic [63:0] k_limb0;
	logic [63:0] k_limb1;
	logic [63:0] k_limb2;
	logic [63:0] k_limb3;

	modport source (output valid, k_limb0, k_limb1, k_limb2, k_limb3, input ready);
	modport sink (input valid, k_limb0, k_limb1, k_limb2, k_limb3, output ready);
endinterface

@@ rtl/core/gss_out_if.sv @@
interface gss_out_if;
	logic valid;
	logic ready;
	logic [63:0] first_mag0;
	logic [63:0] first_mag1;
	logic [63:0] first_mag2;
	logic [63:0] first_mag3;
	logic first_negative;
	logic [63:0] second_mag0;
	logic [63:0] second_mag1;
	logic [63:0] second_mag2;
	logic [63:0] second_mag3;
	logic second_negative;

	modport source (output valid, first_mag0, first_mag1, first_mag2, first_mag3,
		first_negative, second_mag0, second_mag1, second_mag2, second_mag3,
		second_negative, input ready);
	modport sink (input valid, first_mag0, first_mag1, first_mag2, first_mag3,
		first_negative, second_mag0, second_mag1, second_mag2, second_mag3,
		second_negative, output ready);
endinterface

@@ rtl/core/glv_scalar_split.sv @@
// throughput: one item per cycle; each stage holds while the one after it is full
// and stalled, so bubbles close up; the 32x32 partial products and 512-bit adds
// set the stage depth
// reset: arst_n clears the stage valid bits only, data registers are not reset
module glv_scalar_split (
	input logic clk,
	input logic arst_n,
	gss_in_if.sink scalar,
	gss_out_if.source split
);
	import gss_pkg::*;

	logic [NUM_STAGES:1] v;
	logic [NUM_STAGES:1] en;

	u256_t k_in;
	u256_t k_s1;
	u256_t kd_s [2:12];
	logic [63:0] pp_s2 [2][8][8];
	logic [511:0] row_c, row_s3 [2][8];
	logic [511:0] sum_s4 [2][4];
	logic [511:0] sum_s5 [2][2];
	logic [511:0] prod_s6 [2];
	u128_t c_s7 [2];
	u128_t c2d_s [8:13];
	logic [63:0] pq_s8 [4][4][4];
	logic [255:0] rowq_c, rowq_s9 [4][4];
	u256_t sumq_s10 [4][2];
	u256_t pr_s11 [4];
	u256_t k2_s12, t_s12;
	u256_t part_s13, k2_s13;
	u256_t k1_s14, k2_s14;
	u256_t mag1_s15, mag2_s15;
	logic neg1_s15, neg2_s15;
	logic [255:0] even_c, odd_c;
	logic [127:0] evenq_c, oddq_c;

	// a stage loads when it is empty or its content moves on
	always_comb begin
		en[NUM_STAGES] = !v[NUM_STAGES] || split.ready;
		for (int i = NUM_STAGES - 1; i >= 1; i--) begin
			en[i] = !v[i] || en[i + 1];
		end
	end

	assign scalar.ready = en[1];
	assign k_in = {scalar.k_limb3, scalar.k_limb2, scalar.k_limb1, scalar.k_limb0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= scalar.valid;
			for (int i = 2; i <= NUM_STAGES; i++) begin
				if (en[i]) v[i] <= v[i - 1];
			end
		end
	end

	logic [511:0] row_s3_next [2][8];

	// rows of the k*g products: even words do not overlap each other, nor do odd words
	always_comb begin
		row_c = '0;
		even_c = '0;
		odd_c = '0;
		for (int g = 0; g < 2; g++) begin
			for (int i = 0; i < 8; i++) begin
				even_c = {pp_s2[g][i][6], pp_s2[g][i][4], pp_s2[g][i][2], pp_s2[g][i][0]};
				odd_c = {pp_s2[g][i][7], pp_s2[g][i][5], pp_s2[g][i][3], pp_s2[g][i][1]};
				row_c = 512'(even_c) + (512'(odd_c) << 32);
				row_s3_next[g][i] = row_c << (32 * i);
			end
		end
	end

	// rows of the lattice products
	logic [255:0] rowq_s9_next [4][4];
	always_comb begin
		rowq_c = '0;
		evenq_c = '0;
		oddq_c = '0;
		for (int p = 0; p < 4; p++) begin
			for (int i = 0; i < 4; i++) begin
				evenq_c = {pq_s8[p][i][2], pq_s8[p][i][0]};
				oddq_c = {pq_s8[p][i][3], pq_s8[p][i][1]};
				rowq_c = 256'(evenq_c) + (256'(oddq_c) << 32);
				rowq_s9_next[p][i] = rowq_c << (32 * i);
			end
		end
	end

	always_ff @(posedge clk) begin
		// reduce k once below n
		if (en[1]) k_s1 <= (k_in >= ORDER_N) ? k_in - ORDER_N : k_in;

		if (en[2]) begin
			kd_s[2] <= k_s1;
			for (int g = 0; g < 2; g++)
				for (int i = 0; i < 8; i++)
					for (int j = 0; j < 8; j++)
						pp_s2[g][i][j] <= 64'(k_s1[i*32 +: 32]) * 64'(G_MULT[g][j*32 +: 32]);
		end
		for (int s = 3; s <= 12; s++) begin
			if (en[s]) kd_s[s] <= kd_s[s - 1];
		end

		if (en[3]) row_s3 <= row_s3_next;
		if (en[4]) begin
			for (int g = 0; g < 2; g++)
				for (int m = 0; m < 4; m++)
					sum_s4[g][m] <= row_s3[g][2*m] + row_s3[g][2*m + 1];
		end
		if (en[5]) begin
			for (int g = 0; g < 2; g++)
				for (int m = 0; m < 2; m++)
					sum_s5[g][m] <= sum_s4[g][2*m] + sum_s4[g][2*m + 1];
		end
		if (en[6]) begin
			for (int g = 0; g < 2; g++)
				prod_s6[g] <= sum_s5[g][0] + sum_s5[g][1];
		end
		// round on bit 383
		if (en[7]) begin
			for (int g = 0; g < 2; g++)
				c_s7[g] <= prod_s6[g][511:384] + 128'(prod_s6[g][383]);
		end

		if (en[8]) begin
			c2d_s[8] <= c_s7[1];
			for (int p = 0; p < 4; p++)
				for (int i = 0; i < 4; i++)
					for (int j = 0; j < 4; j++)
						pq_s8[p][i][j] <= 64'(c_s7[C_SEL[p]][i*32 +: 32])
							* 64'(L_MULT[p][j*32 +: 32]);
		end
		for (int s = 9; s <= 13; s++) begin
			if (en[s]) c2d_s[s] <= c2d_s[s - 1];
		end

		if (en[9]) rowq_s9 <= rowq_s9_next;
		if (en[10]) begin
			for (int p = 0; p < 4; p++)
				for (int m = 0; m < 2; m++)
					sumq_s10[p][m] <= rowq_s9[p][2*m] + rowq_s9[p][2*m + 1];
		end
		if (en[11]) begin
			for (int p = 0; p < 4; p++)
				pr_s11[p] <= sumq_s10[p][0] + sumq_s10[p][1];
		end

		if (en[12]) begin
			k2_s12 <= sub_mod_n(pr_s11[0], pr_s11[1]);
			t_s12 <= pr_s11[2] + pr_s11[3];
		end
		if (en[13]) begin
			part_s13 <= sub_mod_n(kd_s[12], t_s12);
			k2_s13 <= k2_s12;
		end
		// a2 carries 2^128, so c2*2^128 comes off separately
		if (en[14]) begin
			k1_s14 <= sub_mod_n(part_s13, {c2d_s[13], 128'd0});
			k2_s14 <= k2_s13;
		end
		if (en[15]) begin
			neg1_s15 <= k1_s14 > HALF_N;
			mag1_s15 <= (k1_s14 > HALF_N) ? ORDER_N - k1_s14 : k1_s14;
			neg2_s15 <= k2_s14 > HALF_N;
			mag2_s15 <= (k2_s14 > HALF_N) ? ORDER_N - k2_s14 : k2_s14;
		end
	end

	assign split.valid = v[NUM_STAGES];
	assign split.first_mag0 = mag1_s15[63:0];
	assign split.first_mag1 = mag1_s15[127:64];
	assign split.first_mag2 = mag1_s15[191:128];
	assign split.first_mag3 = mag1_s15[255:192];
	assign split.first_negative = neg1_s15;
	assign split.second_mag0 = mag2_s15[63:0];
	assign split.second_mag1 = mag2_s15[127:64];
	assign split.second_mag2 = mag2_s15[191:128];
	assign split.second_mag3 = mag2_s15[255:192];
	assign split.second_negative = neg2_s15;

endmodule

@@ rtl/core/gss_checker.sv @@
`include "assert_macros.svh"

module gss_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [255:0] first_mag,
	input logic first_neg,
	input logic [255:0] second_mag,
	input logic second_neg
);
	import gss_pkg::*;

	logic stall;
	logic [513:0] out_bits;
	logic first_ok, second_ok;

	assign stall = out_valid && !out_ready;
	assign out_bits = {first_mag, first_neg, second_mag, second_neg};
	assign first_ok = first_mag <= HALF_N && (!first_neg || first_mag != '0);
	assign second_ok = second_mag <= HALF_N && (!second_neg || second_mag != '0);

	// a stalled item stays
	`ASSERT_NEXT(a_hold_valid, clk, arst_n, stall, out_valid, "result item dropped while stalled")
	`ASSERT_NEXT(a_hold_data, clk, arst_n, stall, $stable(out_bits), "stalled result item changed")
	// magnitudes never exceed n/2, and a negated part is never zero
	`ASSERT_NOW(a_first_range, clk, arst_n, out_valid, first_ok, "first magnitude out of range")
	`ASSERT_NOW(a_second_range, clk, arst_n, out_valid, second_ok, "second magnitude out of range")

endmodule

bind glv_scalar_split gss_checker u_gss_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(split.valid),
	.out_ready(split.ready),
	.first_mag({split.first_mag3, split.first_mag2, split.first_mag1, split.first_mag0}),
	.first_neg(split.first_negative),
	.second_mag({split.second_mag3, split.second_mag2, split.second_mag1,
		split.second_mag0}),
	.second_neg(split.second_negative)
);

@@ tb/glv_scalar_split_chk.sv @@
module glv_scalar_split_chk (
	input logic clk,
	input logic arst_n,
	gss_in_if.sink scalar,
	gss_out_if.sink split,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import gss_pkg::*;

	typedef struct packed {
		u256_t first_mag;
		logic first_negative;
		u256_t second_mag;
		logic second_negative;
	} split_t;

	split_t split_q[$];

	function automatic u128_t round_mult(input u256_t k, input u256_t g);
		logic [511:0] p;
		p = {256'd0, k} * {256'd0, g};
		return p[511:384] + 128'(p[383]);
	endfunction

	function automatic u256_t mod_diff(input u256_t a, input u256_t b);
		u256_t d;
		d = a - b;
		if (a < b)
			d = d + ORDER_N;
		return d;
	endfunction

	function automatic split_t predict_split(input u256_t k_in);
		u256_t k, p1, p2, k2, t, k1;
		u128_t c1, c2;
		split_t r;
		k = k_in;
		if (k >= ORDER_N)
			k = k - ORDER_N;
		c1 = round_mult(k, G_MULT[0]);
		c2 = round_mult(k, G_MULT[1]);
		p1 = {128'd0, c1} * {128'd0, NEG_B1};
		p2 = {128'd0, c2} * {128'd0, LAT_B2};
		k2 = mod_diff(p1, p2);
		// a2 = 2^128 + a2lo, high part folded in as c2 << 128
		t = {128'd0, c1} * {128'd0, LAT_B2} + {128'd0, c2} * {128'd0, LAT_A2LO};
		k1 = mod_diff(mod_diff(k, t), {c2, 128'd0});
		r.first_negative = k1 > HALF_N;
		r.first_mag = r.first_negative ? ORDER_N - k1 : k1;
		r.second_negative = k2 > HALF_N;
		r.second_mag = r.second_negative ? ORDER_N - k2 : k2;
		return r;
	endfunction

	assign pending = split_q.size();

	always @(posedge clk or negedge arst_n) begin
		split_t want, got;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (scalar.valid && scalar.ready)
				split_q.push_back(predict_split({scalar.k_limb3, scalar.k_limb2,
					scalar.k_limb1, scalar.k_limb0}));
			if (split.valid && split.ready) begin
				got = {split.first_mag3, split.first_mag2, split.first_mag1,
					split.first_mag0, split.first_negative, split.second_mag3,
					split.second_mag2, split.second_mag1, split.second_mag0,
					split.second_negative};
				if (split_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result item %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = split_q.pop_front();
					if (want.first_mag !== got.first_mag
						|| want.first_negative !== got.first_negative
						|| want.second_mag !== got.second_mag
						|| want.second_negative !== got.second_negative) begin
						if (fail_count < 10)
							$display("mismatch: k1 exp %h/%b got %h/%b, k2 exp %h/%b got %h/%b",
								want.first_mag, want.first_negative, got.first_mag,
								got.first_negative, want.second_mag, want.second_negative,
								got.second_mag, got.second_negative);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

@@ tb/glv_scalar_split_tb.sv @@
module glv_scalar_split_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gss_pkg::*;

	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending;
	int cycle_count = 0;
	bit idle_on = 1'b1;
	bit hold_now = 1'b0;

	gss_in_if scalar_ch ();
	gss_out_if split_ch ();

	glv_scalar_split DUT (.clk(clk), .arst_n(arst_n), .scalar(scalar_ch.sink),
		.split(split_ch.source));
	glv_scalar_split_chk checker_i (.clk(clk), .arst_n(arst_n), .scalar(scalar_ch.sink),
		.split(split_ch.sink), .fail_count(fail_count), .pending(pending));

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		scalar_ch.valid = 1'b0;
		{scalar_ch.k_limb0, scalar_ch.k_limb1, scalar_ch.k_limb2, scalar_ch.k_limb3} = '0;
		split_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("glv_scalar_split_tb NOT OK");
			$finish;
		end
	end

	// receiver stalls in bursts, plus one long hold-off to fill the pipe
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_now) begin
				split_ch.ready <= 1'b0;
				repeat (60) @(posedge clk);
				hold_now = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 11);
				split_ch.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				split_ch.ready <= 1'b1;
			end
		end
	end

	function automatic u256_t rand_u256();
		u256_t v;
		v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = ORDER_N - 256'($urandom_range(0, 3));
			1: v = HALF_N + 256'($urandom_range(0, 2)) - 256'd1;
			2: v = v >> $urandom_range(1, 255);
			3: v = ~(v >> $urandom_range(0, 8));
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_item(input u256_t k);
		int n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 11);
			scalar_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		scalar_ch.valid <= 1'b1;
		{scalar_ch.k_limb3, scalar_ch.k_limb2, scalar_ch.k_limb1, scalar_ch.k_limb0} <= k;
		@(posedge clk);
		while (!scalar_ch.ready)
			@(posedge clk);
	endtask

	initial begin
		u256_t directed [$];
		directed = '{256'd0, 256'd1, 256'd2, ORDER_N - 1, ORDER_N, ORDER_N + 1,
			{256{1'b1}}, HALF_N, HALF_N + 1, HALF_N - 1, {1'b1, 255'd0},
			{128'd0, LAT_B2}, {128'd0, NEG_B1}, {128'd1, 128'd0}, {128'd0, {128{1'b1}}},
			{64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA,
				64'h5555555555555555},
			{64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555,
				64'hAAAAAAAAAAAAAAAA}};
		@(posedge arst_n);
		@(posedge clk);
		foreach (directed[i])
			send_item(directed[i]);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 100)
				hold_now = 1'b1;
			if (i == RANDOM_ITEMS - 60)
				idle_on = 1'b0;
			send_item(rand_u256());
		end
		scalar_ch.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (NUM_STAGES + 10) @(posedge clk);
		if (fail_count == 0)
			$display("glv_scalar_split_tb OK");
		else
			$display("glv_scalar_split_tb NOT OK");
		$finish;
	end
endmodule
